FILE: rtl/core/pott_pkg.sv
// ----------------------------------------------------------------------------
// pott_pkg
// shared types and constants of the periodic / one-shot timer table
// ----------------------------------------------------------------------------
package pott_pkg;

  localparam int NUM_TIMERS  = 16;
  localparam int MAX_RESULTS = 16;
  localparam int IDX_W       = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W       = $clog2(NUM_TIMERS + 1);

  localparam logic [32:0] VECTOR_BASE = 33'd32;

  // request codes
  localparam logic [1:0] REQ_CREATE   = 2'd0;
  localparam logic [1:0] REQ_CANCEL   = 2'd1;
  localparam logic [1:0] REQ_ADVANCE  = 2'd2;
  localparam logic [1:0] REQ_RESERVED = 2'd3;

  // result codes
  localparam logic [1:0] RES_CREATE = 2'd0;
  localparam logic [1:0] RES_CANCEL = 2'd1;
  localparam logic [1:0] RES_IRQ    = 2'd2;

  typedef struct packed {
    logic [31:0] ident;
    logic [63:0] period;
    logic [63:0] deadline;
    logic        repeats;
  } slot_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    slot_t            wr_data;
    logic [IDX_W-1:0] rd_addr;
  } ram_ctrl_t;

endpackage

FILE: rtl/core/pott_slot_ram.sv
// ----------------------------------------------------------------------------
// pott_slot_ram
// timer slot store: one write port, one read port with registered data
// ----------------------------------------------------------------------------
module pott_slot_ram (
  input  logic               clk,
  input  pott_pkg::ram_ctrl_t ctrl,
  output pott_pkg::slot_t    rd_data
);

  pott_pkg::slot_t mem [pott_pkg::NUM_TIMERS];

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[ctrl.wr_addr] <= ctrl.wr_data;
    end
    rd_data <= mem[ctrl.rd_addr];
  end

endmodule

FILE: rtl/core/periodic_oneshot_timer_table.sv
// ----------------------------------------------------------------------------
// periodic_oneshot_timer_table
// software timer table kept packed in creation order in a slot memory
// ----------------------------------------------------------------------------
// create: the slot is written at acceptance, and the result goes out through the
//   response state once the output register is free
// cancel / advance: a memory read state and an evaluate state per live slot,
//   the latter writing back compacted; up to 16 live timers are walked
// one request at a time; output backpressure stalls the slot walk
// synchronous reset clears time, interrupt count and fill count and sets the id counter to 1
module periodic_oneshot_timer_table (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // interval[63:0], repeat_mode[64], cancel_id[96:65], elapsed[160:97]
  input  logic [167:0] s_tdata,
  // req_type[1:0]
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // assigned_id[31:0], success[32], irq_vector[65:33], irq_sequence[129:66]
  output logic [135:0] m_tdata,
  // result_kind[1:0]
  output logic [1:0]   m_tuser,
  output logic         m_tlast
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RD    = 3'd1;
  localparam logic [2:0] ST_EV    = 3'd2;
  localparam logic [2:0] ST_FLUSH = 3'd3;
  localparam logic [2:0] ST_RESP  = 3'd4;

  localparam int CNT_W = pott_pkg::CNT_W;

  logic [2:0] state;

  logic [63:0] cur_time;
  logic [31:0] next_id;
  logic [63:0] irq_count;
  logic [pott_pkg::CNT_W-1:0] count;
  logic [pott_pkg::IDX_W-1:0] rd_idx;
  logic [pott_pkg::CNT_W-1:0] wr_cnt;
  logic        mode_cancel;
  logic        found;
  logic [31:0] cid;

  // pending interrupt, held until we know whether it is the last one
  logic        pend_valid;
  logic [32:0] pend_vec;
  logic [63:0] pend_seq;

  // response held for the output register
  logic [1:0]  resp_kind;
  logic [31:0] resp_id;
  logic        resp_ok;

  logic [1:0]  out_kind;
  logic [31:0] out_id;
  logic        out_ok;
  logic [32:0] out_vec;
  logic [63:0] out_seq;
  logic        out_last;
  logic        out_valid;

  pott_pkg::ram_ctrl_t ram_ctrl;
  pott_pkg::slot_t     rd_data;

  logic [63:0] in_interval;
  logic        in_repeat;
  logic [31:0] in_cancel_id;
  logic [63:0] in_elapsed;

  logic out_free;
  logic out_load;
  logic accept;
  logic due;
  logic hit;
  logic stall;
  logic keep;
  logic sweep_end;
  logic [pott_pkg::CNT_W-1:0] wr_cnt_next;
  pott_pkg::slot_t keep_entry;

  assign in_interval  = s_tdata[63:0];
  assign in_repeat    = s_tdata[64];
  assign in_cancel_id = s_tdata[96:65];
  assign in_elapsed   = s_tdata[160:97];

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !out_valid || m_tready;

  assign due   = (cur_time >= rd_data.deadline);
  assign hit   = (rd_data.ident == cid);
  assign stall = !mode_cancel && due && pend_valid && !out_free;
  assign keep  = mode_cancel ? !hit : (!due || rd_data.repeats);
  assign wr_cnt_next = keep ? wr_cnt + 1'b1 : wr_cnt;
  assign sweep_end = ({1'b0, rd_idx} == count - 1'b1);

  // output register takes a new transaction this cycle
  assign out_load = (state == ST_EV && !stall && !mode_cancel && due && pend_valid) ||
                    ((state == ST_FLUSH || state == ST_RESP) && out_free);

  always_comb begin
    keep_entry = rd_data;
    if (!mode_cancel && due) begin
      keep_entry.deadline = rd_data.deadline + rd_data.period;
    end
  end

  always_comb begin
    ram_ctrl.rd_addr = rd_idx;
    ram_ctrl.wr_en   = 1'b0;
    ram_ctrl.wr_addr = wr_cnt[pott_pkg::IDX_W-1:0];
    ram_ctrl.wr_data = keep_entry;
    if (accept && s_tuser == pott_pkg::REQ_CREATE) begin
      ram_ctrl.wr_addr          = count[pott_pkg::IDX_W-1:0];
      ram_ctrl.wr_data.ident    = next_id;
      ram_ctrl.wr_data.period   = in_interval;
      ram_ctrl.wr_data.deadline = cur_time + in_interval;
      ram_ctrl.wr_data.repeats  = in_repeat;
      ram_ctrl.wr_en = (in_interval != 64'd0) && (count < CNT_W'(pott_pkg::NUM_TIMERS));
    end else if (state == ST_EV && !stall) begin
      ram_ctrl.wr_en = keep;
    end
  end

  pott_slot_ram u_ram (
    .clk     (clk),
    .ctrl    (ram_ctrl),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cur_time   <= 64'd0;
      next_id    <= 32'd1;
      irq_count  <= 64'd0;
      count      <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            rd_idx <= '0;
            wr_cnt <= '0;
            found  <= 1'b0;
            cid    <= in_cancel_id;
            unique case (s_tuser)
              pott_pkg::REQ_CREATE: begin
                resp_kind <= pott_pkg::RES_CREATE;
                resp_ok   <= ram_ctrl.wr_en;
                resp_id   <= ram_ctrl.wr_en ? next_id : 32'd0;
                if (ram_ctrl.wr_en) begin
                  count   <= count + 1'b1;
                  next_id <= (next_id + 32'd1 == 32'd0) ? 32'd1 : next_id + 32'd1;
                end
                state <= ST_RESP;
              end
              pott_pkg::REQ_CANCEL: begin
                mode_cancel <= 1'b1;
                resp_kind   <= pott_pkg::RES_CANCEL;
                resp_id     <= 32'd0;
                resp_ok     <= 1'b0;
                state       <= (count == '0) ? ST_RESP : ST_RD;
              end
              pott_pkg::REQ_ADVANCE: begin
                mode_cancel <= 1'b0;
                cur_time    <= cur_time + in_elapsed;
                state       <= (count == '0) ? ST_IDLE : ST_RD;
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_RD: state <= ST_EV;
        ST_EV: begin
          if (!stall) begin
            wr_cnt <= wr_cnt_next;
            if (mode_cancel) begin
              found   <= found || hit;
              resp_ok <= found || hit;
            end else if (due) begin
              if (pend_valid) begin
                out_kind  <= pott_pkg::RES_IRQ;
                out_id    <= 32'd0;
                out_ok    <= 1'b0;
                out_vec   <= pend_vec;
                out_seq   <= pend_seq;
                out_last  <= 1'b0;
              end
              pend_valid <= 1'b1;
              pend_vec   <= pott_pkg::VECTOR_BASE + {1'b0, rd_data.ident};
              pend_seq   <= irq_count;
              irq_count  <= irq_count + 64'd1;
            end
            if (sweep_end) begin
              count <= wr_cnt_next;
              if (mode_cancel) begin
                state <= ST_RESP;
              end else if (pend_valid || due) begin
                state <= ST_FLUSH;
              end else begin
                state <= ST_IDLE;
              end
            end else begin
              rd_idx <= rd_idx + 1'b1;
              state  <= ST_RD;
            end
          end
        end
        ST_FLUSH: begin
          if (out_free) begin
            out_kind   <= pott_pkg::RES_IRQ;
            out_id     <= 32'd0;
            out_ok     <= 1'b0;
            out_vec    <= pend_vec;
            out_seq    <= pend_seq;
            out_last   <= 1'b1;
            pend_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        ST_RESP: begin
          if (out_free) begin
            out_kind  <= resp_kind;
            out_id    <= resp_id;
            out_ok    <= resp_ok;
            out_vec   <= 33'd0;
            out_seq   <= 64'd0;
            out_last  <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;
  assign m_tdata  = {6'd0, out_seq, out_vec, out_ok, out_id};

  // fill count stays within the table
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(pott_pkg::NUM_TIMERS))
    else $error("timer count beyond table size");

  // no interrupt left pending once back at idle
  a_pend_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !pend_valid)
    else $error("pending interrupt dropped");

  // an interrupt result carries a vector at or above the base
  a_irq_vec: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind == pott_pkg::RES_IRQ) |-> (out_vec >= pott_pkg::VECTOR_BASE))
    else $error("interrupt vector below base");

  // the slot walk never writes ahead of the read position
  a_compact: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EV) |-> (wr_cnt <= {1'b0, rd_idx}))
    else $error("compaction write ahead of read");

endmodule
